// File: design/pbrt_pkg.sv
// Shared types, codes and helpers for the priority bitmap ready table.
// Used by pbrt_find_first and priority_bitmap_ready_table; no dependencies.
package pbrt_pkg;

  // Operation codes
  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;

  // Slots per row and the widest table the encoders cover
  localparam int ROW_W   = 8;
  localparam int ROW_SEL = 3;
  localparam int MAX_W   = 64;

  typedef struct packed {
    logic       op;
    logic [7:0] priority_req;
    logic [7:0] task_handle;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] removed_handle;
    logic [5:0] highest_ready;
    logic       any_ready;
  } rsp_t;

  // Outcome of the two-level lowest-set search
  typedef struct packed {
    logic [5:0] highest;
    logic       any;
  } find_t;

  // Position of the lowest set bit of a byte; 0 when the byte is empty
  function automatic logic [ROW_SEL-1:0] lowest_set8(input logic [ROW_W-1:0] v);
    logic [ROW_SEL-1:0] pos;
    pos = '0;
    for (int i = ROW_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        pos = ROW_SEL'(i);
      end
    end
    return pos;
  endfunction

endpackage

// File: design/pbrt_find_first.sv
// Two-level find-lowest-set over the ready bitmap: group bits, then one row.
// Depends on pbrt_pkg.
module pbrt_find_first (
  input  logic [pbrt_pkg::MAX_W-1:0] bits,
  output pbrt_pkg::find_t            found
);

  localparam int ROWS = pbrt_pkg::MAX_W / pbrt_pkg::ROW_W;

  logic [ROWS-1:0]                 group;
  logic [pbrt_pkg::ROW_SEL-1:0]    grp_sel;
  logic [pbrt_pkg::ROW_W-1:0]      row;

  // Build group bits, one per nonzero row
  always_comb begin
    for (int g = 0; g < ROWS; g++) begin
      group[g] = |bits[g*pbrt_pkg::ROW_W +: pbrt_pkg::ROW_W];
    end
  end

  // Pick the lowest ready row, then the lowest ready slot within it
  assign grp_sel = pbrt_pkg::lowest_set8(group);
  assign row     = bits[grp_sel*pbrt_pkg::ROW_W +: pbrt_pkg::ROW_W];

  assign found.any     = |group;
  assign found.highest = found.any ? {grp_sel, pbrt_pkg::lowest_set8(row)} : 6'd0;

endmodule

// File: design/priority_bitmap_ready_table.sv
// Priority bitmap ready table: top level with handle memory and ready bitmap.
// Depends on pbrt_pkg and pbrt_find_first.
//
// An item is taken when start is high and busy is low; busy then stays high
// for one cycle, during which no new item is taken. On acceptance the slot's
// handle is read from the single-port handle memory into a register; while
// busy the block updates the ready bitmap, writes the handle on an add to a
// slot not yet ready and registers the result. done is high for exactly one
// cycle, the cycle after busy, with the item's result on result; the receiver
// cannot hold it off, so it must take the result in that cycle. Ready bits
// clear at reset; the handle memory needs no clearing: a handle is used only once ready.
module priority_bitmap_ready_table #(
  parameter int NUM_PRIORITIES = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  pbrt_pkg::req_t req,
  output logic           done,
  output pbrt_pkg::rsp_t result
);

  localparam int IDX_W = $clog2(NUM_PRIORITIES);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t              state;
  state_t              state_next;

  // Latched item
  pbrt_pkg::req_t      cur;
  logic                cur_valid;

  // Handle memory
  logic [7:0]          handle_mem [NUM_PRIORITIES];
  logic [7:0]          rd_data;
  logic                mem_re;
  logic                mem_we;

  // Ready bitmap, one bit per slot
  logic [NUM_PRIORITIES-1:0] ready;
  logic [NUM_PRIORITIES-1:0] ready_next;
  logic [NUM_PRIORITIES-1:0] slot_bit;
  logic [IDX_W-1:0]          in_slot;
  logic [IDX_W-1:0]          slot;
  logic                      in_valid;
  logic                      hit;

  pbrt_pkg::find_t     found;
  pbrt_pkg::rsp_t      rsp_next;

  // Decode the incoming priority
  assign in_valid = 32'(req.priority_req) < NUM_PRIORITIES;
  assign in_slot  = req.priority_req[IDX_W-1:0];
  assign slot     = cur.priority_req[IDX_W-1:0];
  assign slot_bit = {{(NUM_PRIORITIES-1){1'b0}}, 1'b1} << slot;
  assign hit      = ready[slot];

  assign busy   = (state == S_EXEC);
  assign mem_re = start && !busy && in_valid;

  // Advance the sequencer
  always_comb begin
    unique case (state)
      S_IDLE:  state_next = (start) ? S_EXEC : S_IDLE;
      S_EXEC:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the accepted item
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cur       <= req;
      cur_valid <= in_valid;
    end
  end

  // Read and write the handle memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      handle_mem[slot] <= cur.task_handle;
    end
    if (mem_re) begin
      rd_data <= handle_mem[in_slot];
    end
  end

  // Work out the bitmap update
  always_comb begin
    ready_next = ready;
    mem_we     = 1'b0;
    if (busy && cur_valid) begin
      if (cur.op == pbrt_pkg::OP_ADD) begin
        ready_next = ready | slot_bit;
        mem_we     = !hit;
      end else if (hit) begin
        ready_next = ready & ~slot_bit;
      end
    end
  end

  // Build the result from the item and the updated bitmap
  always_comb begin
    rsp_next.status         = pbrt_pkg::ST_OK;
    rsp_next.removed_handle = 8'd0;
    priority if (!cur_valid) begin
      rsp_next.status = pbrt_pkg::ST_INVALID;
    end else if (cur.op == pbrt_pkg::OP_ADD) begin
      rsp_next.status = pbrt_pkg::ST_OK;
    end else if (hit) begin
      rsp_next.removed_handle = rd_data;
    end else begin
      rsp_next.status = pbrt_pkg::ST_EMPTY;
    end
    rsp_next.highest_ready = found.highest;
    rsp_next.any_ready     = found.any;
  end

  pbrt_find_first u_find (
    .bits  (pbrt_pkg::MAX_W'(ready_next)),
    .found (found)
  );

  // Update the bitmap
  always_ff @(posedge clk) begin
    if (rst) begin
      ready <= '0;
    end else begin
      ready <= ready_next;
    end
  end

  // Register the result and its strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      result <= rsp_next;
    end
  end

endmodule
